// ----- rtl/core/spb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sound peak to brightness block.
// Holds the sequencer state type, register indexes and fixed constants.
package spb_pkg;

  // brightness width; also the number of divider steps
  localparam int unsigned BRIGHT_BITS = 8;
  localparam int unsigned STEP_BITS   = $clog2(BRIGHT_BITS);

  // threshold value after reset
  localparam int unsigned THRESH_RESET = 5;

  // configuration register indexes
  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_QUIET  = 1'b0;
  localparam reg_index_t REG_THRESH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/core/sound_peak_to_brightness.sv -----
`timescale 1ns / 1ps
// Sound peak to brightness: window peak meter with a shared divider.
// Depends on spb_pkg.
//
// Usage:
//   Slave stream carries microphone samples (tdata) with tlast marking the
//   last sample of a measurement window. Each accepted beat is folded into
//   the window peak as |sample - quiet_level|. A beat with tlast closes the
//   window and produces exactly one master beat holding the brightness:
//   0 when the peak does not exceed noise_threshold, otherwise
//   (peak - thr) * 255 / (alltime - thr), rounded down.
//   Beats without tlast produce nothing.
//   A window-closing beat above threshold keeps s_tready low through the
//   check state, the scale state, 8 restoring divider steps (one quotient
//   bit per cycle through a single compare/subtract unit), and the state
//   that loads the output register.
//   A dark window skips scale and divide and goes from check to load.
//   The output register holds the result until taken; samples without
//   tlast are still accepted while it waits. A second result stalls in the
//   final state until the register frees up.
//   Reset (synchronous, active high) clears window and all-time peaks,
//   quiet_level to 0, noise_threshold to 5, and drops m_tvalid.
//   Config writes (cfg_we) take effect on the next beat; write only while
//   idle.
module sound_peak_to_brightness #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] mic_sample
  input  logic                                 s_tlast,   // window_end
  // master stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [spb_pkg::BRIGHT_BITS-1:0]      m_tdata,   // [7:0] brightness
  // config write port
  input  logic                                 cfg_we,
  input  spb_pkg::reg_index_t                  cfg_addr,
  input  logic [SAMPLE_BITS-1:0]               cfg_wdata
);
  import spb_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned DW = SAMPLE_BITS + BRIGHT_BITS;  // scaled numerator width

  state_t state, state_next;

  // config registers
  logic [SW-1:0] quiet_level;
  logic [SW-1:0] noise_threshold;

  // peak state
  logic [SW-1:0] window_peak;
  logic [SW-1:0] alltime_peak;

  // divider
  logic [DW-1:0]          rem;      // running remainder / numerator
  logic [DW-1:0]          dsr;      // shifted divisor
  logic [BRIGHT_BITS-1:0] quo;
  logic [STEP_BITS-1:0]   step;

  // output register
  logic                   out_valid;
  logic [BRIGHT_BITS-1:0] out_data;

  // control
  logic          in_beat;
  logic          out_load;
  logic [SW-1:0] sample;
  logic [SW-1:0] mag;
  logic          above;
  logic [SW-1:0] alltime_upd;
  logic          rem_ge;

  assign sample  = s_tdata[SW-1:0];
  assign in_beat = s_tvalid && s_tready;
  assign mag     = (sample >= quiet_level) ? (sample - quiet_level) : (quiet_level - sample);
  assign above   = window_peak > noise_threshold;
  assign alltime_upd = (window_peak > alltime_peak) ? window_peak : alltime_peak;
  assign rem_ge  = rem >= dsr;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_beat && s_tlast) state_next = ST_CHECK;
      ST_CHECK: state_next = above ? ST_SCALE : ST_OUT;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   if (step == STEP_BITS'(BRIGHT_BITS - 1)) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_OUT:  out_load = !out_valid || m_tready;
      default: begin
        s_tready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      quiet_level     <= '0;
      noise_threshold <= SW'(THRESH_RESET);
      window_peak     <= '0;
      alltime_peak    <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_addr)
          REG_QUIET:  quiet_level     <= cfg_wdata;
          REG_THRESH: noise_threshold <= cfg_wdata;
          default:    ;
        endcase
      end

      // sample folds into the window peak before the window-end check
      if (in_beat && mag > window_peak) window_peak <= mag;

      if (state == ST_CHECK) begin
        window_peak <= '0;
        if (above) alltime_peak <= alltime_upd;
      end

      if (out_load)            out_valid <= 1'b1;
      else if (m_tready)       out_valid <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        rem  <= {{BRIGHT_BITS{1'b0}}, window_peak - noise_threshold};
        quo  <= '0;
        step <= '0;
      end
      ST_SCALE: begin
        // x * 255 = (x << 8) - x; span uses the updated all-time peak
        rem <= (rem << BRIGHT_BITS) - rem;
        dsr <= {1'b0, alltime_peak - noise_threshold, {(BRIGHT_BITS-1){1'b0}}};
      end
      ST_DIV: begin
        if (rem_ge) rem <= rem - dsr;
        dsr  <= dsr >> 1;
        quo  <= {quo[BRIGHT_BITS-2:0], rem_ge};
        step <= step + 1'b1;
      end
      default: ;
    endcase
    if (out_load) out_data <= quo;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- rtl/core/spb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for sound_peak_to_brightness, bound into that module.
// Depends on spb_pkg.
module spb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spb_pkg::BRIGHT_BITS-1:0] m_tdata
);
  import spb_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // a beat that does not close a window never yields a result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
    else $error("result without window end");

  // closing a window starts the busy computation
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready during computation");

  // a new result only appears at the end of a busy period
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind sound_peak_to_brightness spb_checker u_spb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/spb_bright_checker.sv -----
`timescale 1ns / 1ps
// Brightness checker for sound_peak_to_brightness: watches both streams
// and the config port, predicts every window result and compares it.
// Depends on spb_pkg.
module spb_bright_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] mic_sample
  input  logic                                 s_tlast,   // window_end
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [spb_pkg::BRIGHT_BITS-1:0]      m_tdata,   // [7:0] brightness
  input  logic                                 cfg_we,
  input  spb_pkg::reg_index_t                  cfg_addr,
  input  logic [SAMPLE_BITS-1:0]               cfg_wdata,
  output int unsigned                          fail_count,
  output int unsigned                          pending
);

  localparam int unsigned FULL_SCALE = 255;

  logic [SAMPLE_BITS-1:0]          quiet_lvl;
  logic [SAMPLE_BITS-1:0]          noise_thr;
  logic [SAMPLE_BITS-1:0]          win_peak;
  logic [SAMPLE_BITS-1:0]          peak_hold;
  logic [spb_pkg::BRIGHT_BITS-1:0] bright_due[$];
  logic [spb_pkg::BRIGHT_BITS-1:0] want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic note_fail(input string msg);
    if (fail_count < 10) $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  // fold one sample into the window; on window end queue the brightness
  task automatic fold_sample(input logic [SAMPLE_BITS-1:0] smp, input logic closes);
    logic [SAMPLE_BITS-1:0] mag;
    int unsigned            lvl;
    mag = (smp >= quiet_lvl) ? smp - quiet_lvl : quiet_lvl - smp;
    if (mag > win_peak) win_peak = mag;
    if (closes) begin
      lvl = 0;
      if (win_peak > noise_thr) begin
        if (win_peak > peak_hold) peak_hold = win_peak;
        lvl = ((int'(win_peak) - int'(noise_thr)) * FULL_SCALE)
              / (int'(peak_hold) - int'(noise_thr));
        if (lvl > FULL_SCALE) lvl = FULL_SCALE;
      end
      bright_due.push_back(lvl[spb_pkg::BRIGHT_BITS-1:0]);
      win_peak = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_lvl = '0;
      noise_thr = SAMPLE_BITS'(spb_pkg::THRESH_RESET);
      win_peak  = '0;
      peak_hold = '0;
      bright_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (bright_due.size() == 0) begin
          note_fail($sformatf("unexpected brightness beat %0d", m_tdata));
        end else begin
          want = bright_due.pop_front();
          if (m_tdata !== want)
            note_fail($sformatf("brightness expected %0d got %0d", want, m_tdata));
        end
      end
      if (s_tvalid && s_tready) fold_sample(s_tdata[SAMPLE_BITS-1:0], s_tlast);
      // new register values count from the next beat on
      if (cfg_we) begin
        case (cfg_addr)
          spb_pkg::REG_QUIET:  quiet_lvl = cfg_wdata;
          spb_pkg::REG_THRESH: noise_thr = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending <= bright_due.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the sound_peak_to_brightness testbench: clock, reset, stimulus,
// stall patterns, verdict. Depends on spb_pkg, spb_bright_checker, the DUT.
module tb_top;

  localparam int unsigned SMP_BITS    = 12;
  localparam int unsigned TDATA_W     = ((SMP_BITS + 7) / 8) * 8;
  localparam int unsigned SMP_MAX     = (1 << SMP_BITS) - 1;
  localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned SETTLE      = 20;   // outlasts the window-end busy time
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 120;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [TDATA_W-1:0]              s_tdata   = '0;  // [11:0] mic_sample
  logic                            s_tlast   = 1'b0; // window_end
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [spb_pkg::BRIGHT_BITS-1:0] m_tdata;          // [7:0] brightness
  logic                            cfg_we    = 1'b0;
  spb_pkg::reg_index_t             cfg_addr  = spb_pkg::REG_QUIET;
  logic [SMP_BITS-1:0]             cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;

  // set by the stimulus; calm and long_hold are shared with the receiver
  bit                  calm      = 1'b0;  // end of run: no idling at all
  bit                  long_hold = 1'b0;  // ask the receiver for a long stall
  int unsigned         src_gap_pct = 0;   // sender idle chance per beat
  logic [SMP_BITS-1:0] cur_quiet = '0;    // tracks quiet_level for sample shaping

  sound_peak_to_brightness #(
    .SAMPLE_BITS(SMP_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  spb_bright_checker #(
    .SAMPLE_BITS(SMP_BITS)
  ) u_chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop; a correct run of ~1100 beats with worst stalls needs well
  // under a quarter of this.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver side. Stall density is re-picked every 64 draws so some
  // stretches run with m_tready solid high. A long_hold request pins
  // m_tready low for HOLD_CYCLES so the output register and the window-end
  // sequencer back up into s_tready.
  initial begin
    int unsigned left;
    int unsigned pct;
    left = 0;
    pct  = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 5;
          default: pct = 25;
        endcase
        left = 64;
      end
      left--;
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && pct != 0 && $urandom_range(0, 99) < pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One sample beat; returns at the edge where it was taken.
  // An idle burst, when drawn, goes in front of the beat.
  task automatic send_beat(input logic [SMP_BITS-1:0] smp, input logic last);
    if (!calm && src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(smp);
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Full-range in 4 of 10 draws, with weight on the quiet level and the rails so
  // threshold-equal peaks and below-quiet samples come up often.
  function automatic logic [SMP_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, SMP_MAX));
      4, 5, 6:    v = int'(cur_quiet) + int'($urandom_range(0, 128)) - 64;
      7:          v = 0;
      8:          v = SMP_MAX;
      default:    v = int'(cur_quiet);
    endcase
    if (v < 0) v = 0;
    if (v > int'(SMP_MAX)) v = SMP_MAX;
    return SMP_BITS'(v);
  endfunction

  task automatic send_window(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(pick_sample(), i == len - 1);
  endtask

  // Sender pauses until every brightness beat is back, then gives the
  // sequencer time to settle before any register write.
  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input spb_pkg::reg_index_t idx, input logic [SMP_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == spb_pkg::REG_QUIET) cur_quiet = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // --- directed: reset registers (quiet 0, threshold 5) ---
    send_beat(12'd0, 1'b1);      // silent window
    send_beat(12'd5, 1'b1);      // peak equal to threshold: dark, all-time untouched
    send_beat(12'd6, 1'b1);      // first peak over threshold: full scale
    send_beat(12'd4095, 1'b1);   // top of range raises the all-time peak
    send_beat(12'd100, 1'b0);
    send_beat(12'd6, 1'b1);      // sample before the close still counts
    send_beat(12'd3000, 1'b0);
    send_beat(12'd50, 1'b0);
    send_beat(12'd10, 1'b1);     // closing sample smaller than window peak
    drain();

    // mid quiet level, zero threshold; samples on both sides of quiet
    write_reg(spb_pkg::REG_QUIET, 12'd2048);
    write_reg(spb_pkg::REG_THRESH, 12'd0);
    send_beat(12'd0, 1'b1);      // below quiet level
    send_beat(12'd4095, 1'b1);
    send_beat(12'd2048, 1'b1);   // zero magnitude, zero threshold: still dark
    send_beat(12'd2049, 1'b1);   // smallest nonzero step truncates to zero
    drain();

    // quiet at the top rail, threshold at its highest mapped value
    write_reg(spb_pkg::REG_QUIET, 12'd4095);
    write_reg(spb_pkg::REG_THRESH, 12'd4094);
    send_beat(12'd0, 1'b1);
    send_beat(12'd1, 1'b1);
    drain();

    // threshold at full range: nothing can be above it
    write_reg(spb_pkg::REG_QUIET, 12'd0);
    write_reg(spb_pkg::REG_THRESH, 12'd4095);
    send_beat(12'd4095, 1'b1);
    send_beat(12'd0, 1'b1);
    drain();

    // --- random phases, each with its own register setting ---
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(spb_pkg::REG_QUIET, 12'd2048);
          write_reg(spb_pkg::REG_THRESH, 12'd5);
        end
        1: begin
          write_reg(spb_pkg::REG_QUIET, 12'd0);
          write_reg(spb_pkg::REG_THRESH, 12'd0);
        end
        2: begin
          write_reg(spb_pkg::REG_QUIET, 12'd4095);
          write_reg(spb_pkg::REG_THRESH, 12'd4094);
        end
        default: begin
          write_reg(spb_pkg::REG_QUIET, SMP_BITS'($urandom_range(0, SMP_MAX)));
          if ($urandom_range(0, 3) == 0)
            write_reg(spb_pkg::REG_THRESH, SMP_BITS'($urandom_range(0, SMP_MAX)));
          else
            write_reg(spb_pkg::REG_THRESH, SMP_BITS'($urandom_range(0, 400)));
        end
      endcase

      if (ph == PHASES - 1) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 10;
        default: src_gap_pct = 40;
      endcase

      // one phase runs into a long output stall: short windows keep
      // results coming so the block has to hold off its input
      if (ph == 3) begin
        long_hold = 1'b1;
        for (int unsigned k = 0; k < 40; k++) send_window($urandom_range(1, 3));
        while (long_hold) @(posedge clk);
      end

      sent = 0;
      while (sent < PHASE_BEATS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        send_window(len);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sound_peak_to_brightness.f -----
rtl/core/spb_pkg.sv
rtl/core/sound_peak_to_brightness.sv
rtl/core/spb_checker.sv
tb/sv/spb_bright_checker.sv
tb/sv/tb_top.sv
